// ===== design/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared constants and types for the reduced GF(2) basis insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbi_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int VEC_W         = 32;
	localparam int PIV_W         = 5;
	localparam int RANK_W        = 6;

	localparam logic [RANK_W-1:0] RANK_MAX = '1;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// control part of the token that walks down the cell chain
	typedef struct packed {
		logic       active;
		logic [1:0] op;
		logic       found;
		logic       hit;
	} gbi_ctl_t;

endpackage

`default_nettype wire

// ===== design/gbi_cell.sv =====
// ----------------------------------------------------------------------------
// gbi_cell
// One pivot cell: holds the basis row whose leading bit is IDX, reduces the
// passing word against it, tracks the leading bit and answers row reads.
// ----------------------------------------------------------------------------
`default_nettype none

module gbi_cell import gbi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int IW        = 5,
	parameter int IDX       = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire gbi_ctl_t             ctl_in,
	input  wire logic [WORD_BITS-1:0] w_in,
	input  wire logic [IW-1:0]        lead_in,
	input  wire logic [WORD_BITS-1:0] rowv_in,
	input  wire logic [PIV_W-1:0]     piv_in,
	output gbi_ctl_t                  ctl_out,
	output logic [WORD_BITS-1:0]      w_out,
	output logic [IW-1:0]             lead_out,
	output logic [WORD_BITS-1:0]      rowv_out,
	output logic [PIV_W-1:0]          piv_out,
	input  wire logic                 upd_en,
	input  wire logic [IW-1:0]        upd_lead,
	input  wire logic [WORD_BITS-1:0] upd_word
);

	localparam logic [IW-1:0] MY_LEAD = IW'(IDX);
	localparam logic [6:0]    MY_PIV  = 7'(IDX);

	logic [WORD_BITS-1:0] row_q;
	logic                 valid_q;

	gbi_ctl_t             ctl_q;
	logic [WORD_BITS-1:0] w_q;
	logic [IW-1:0]        lead_q;
	logic [WORD_BITS-1:0] rowv_q;
	logic [PIV_W-1:0]     piv_q;

	logic [WORD_BITS-1:0] w_red;
	logic                 new_lead;
	logic                 read_hit;

	always_comb begin
		w_red    = (valid_q && w_in[IDX]) ? (w_in ^ row_q) : w_in;
		new_lead = !ctl_in.found && w_red[IDX];
		read_hit = (ctl_in.op == OP_READ) && valid_q && ({2'b00, piv_in} == MY_PIV);
	end

	// row storage and basis update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			row_q   <= '0;
		end else if (upd_en) begin
			if (upd_lead == MY_LEAD) begin
				row_q   <= upd_word;
				valid_q <= 1'b1;
			end else if (valid_q && (upd_lead < MY_LEAD) && row_q[upd_lead]) begin
				row_q <= row_q ^ upd_word;
			end
		end
	end

	// token register toward the next lower cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q  <= '0;
			w_q    <= '0;
			lead_q <= '0;
			rowv_q <= '0;
			piv_q  <= '0;
		end else begin
			ctl_q.active <= ctl_in.active;
			ctl_q.op     <= ctl_in.op;
			ctl_q.found  <= ctl_in.found || new_lead;
			ctl_q.hit    <= ctl_in.hit || read_hit;
			w_q          <= w_red;
			lead_q       <= new_lead ? MY_LEAD : lead_in;
			rowv_q       <= read_hit ? row_q : rowv_in;
			piv_q        <= piv_in;
		end
	end

	assign ctl_out  = ctl_q;
	assign w_out    = w_q;
	assign lead_out = lead_q;
	assign rowv_out = rowv_q;
	assign piv_out  = piv_q;

endmodule

`default_nettype wire

// ===== design/gf2_reduced_basis_insert.sv =====
// ----------------------------------------------------------------------------
// gf2_reduced_basis_insert
// Reduced-echelon GF(2) basis with insert, span query and row read.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its token walks
// the row of WORD_BITS pivot cells from the highest pivot down, one cell per
// cycle, and the result is registered onto done as the token leaves the lowest
// cell, and busy keeps out a new transaction until then. done is high for a
// single cycle with the result; there is no back-pressure on the result side.
// rank is the basis size after the transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module gf2_reduced_basis_insert import gbi_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [VEC_W-1:0]  vector,
	input  wire logic [PIV_W-1:0]  pivot_index,
	output logic                   done,
	output logic                   in_span,
	output logic [RANK_W-1:0]      rank,
	output logic [VEC_W-1:0]       row_value,
	output logic                   row_present
);

	localparam int IW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	gbi_ctl_t             ctl  [WORD_BITS+1];
	logic [WORD_BITS-1:0] w    [WORD_BITS+1];
	logic [IW-1:0]        lead [WORD_BITS+1];
	logic [WORD_BITS-1:0] rowv [WORD_BITS+1];
	logic [PIV_W-1:0]     piv  [WORD_BITS+1];

	logic                 busy_q;
	logic                 done_q;
	logic                 in_span_q;
	logic [RANK_W-1:0]    rank_q;
	logic [VEC_W-1:0]     row_value_q;
	logic                 row_present_q;

	logic                 accept;
	logic                 upd_en;
	logic                 span_op;

	assign accept = start && !busy_q;

	always_comb begin
		ctl[WORD_BITS].active = accept;
		ctl[WORD_BITS].op     = op;
		ctl[WORD_BITS].found  = 1'b0;
		ctl[WORD_BITS].hit    = 1'b0;
		w[WORD_BITS]          = WORD_BITS'(vector);
		lead[WORD_BITS]       = '0;
		rowv[WORD_BITS]       = '0;
		piv[WORD_BITS]        = pivot_index;
	end

	for (genvar p = 0; p < WORD_BITS; p++) begin : g_cell
		gbi_cell #(
			.WORD_BITS (WORD_BITS),
			.IW        (IW),
			.IDX       (p)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   (ctl[p+1]),
			.w_in     (w[p+1]),
			.lead_in  (lead[p+1]),
			.rowv_in  (rowv[p+1]),
			.piv_in   (piv[p+1]),
			.ctl_out  (ctl[p]),
			.w_out    (w[p]),
			.lead_out (lead[p]),
			.rowv_out (rowv[p]),
			.piv_out  (piv[p]),
			.upd_en   (upd_en),
			.upd_lead (lead[0]),
			.upd_word (w[0])
		);
	end

	assign span_op = (ctl[0].op == OP_INSERT) || (ctl[0].op == OP_QUERY);
	assign upd_en  = ctl[0].active && (ctl[0].op == OP_INSERT) && ctl[0].found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			done_q        <= 1'b0;
			in_span_q     <= 1'b0;
			rank_q        <= '0;
			row_value_q   <= '0;
			row_present_q <= 1'b0;
		end else begin
			done_q <= ctl[0].active;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (ctl[0].active) begin
				busy_q <= 1'b0;
			end
			if (ctl[0].active) begin
				in_span_q     <= span_op && !ctl[0].found;
				row_present_q <= (ctl[0].op == OP_READ) && ctl[0].hit;
				row_value_q   <= ((ctl[0].op == OP_READ) && ctl[0].hit) ?
				                 VEC_W'(rowv[0]) : '0;
				if (upd_en && (rank_q != RANK_MAX)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign in_span     = in_span_q;
	assign rank        = rank_q;
	assign row_value   = row_value_q;
	assign row_present = row_present_q;

endmodule

`default_nettype wire
